[src/ismu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ismu_pkg
// shared types and constants of the ising metropolis site update block
// ----------------------------------------------------------------------------
package ismu_pkg;

    // default lattice side length
    localparam int SIDE_DEFAULT = 16;

    // action codes carried in tuser of the input stream
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // register file
    localparam int CFG_AW = 4;
    localparam logic [1:0] REG_COUPLING     = 2'd0;
    localparam logic [1:0] REG_ACCEPT_SMALL = 2'd1;
    localparam logic [1:0] REG_ACCEPT_LARGE = 2'd2;
    localparam logic [3:0] COUPLING_RESET   = 4'sd1;
    localparam logic [3:0] COUPLING_MIN_RAW = 4'b1000;
    localparam logic [3:0] COUPLING_FLOOR   = 4'b1001;

    typedef struct packed {
        logic signed [3:0] coupling;
        logic [15:0]       accept_small;
        logic [15:0]       accept_large;
    } cfg_t;

    typedef struct packed {
        logic signed [6:0]  delta;
        logic               flip;
        logic signed [12:0] energy;
    } eval_t;

endpackage

[src/ising_metropolis_site_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// metropolis single-site update of a periodic square ising lattice
// ----------------------------------------------------------------------------
// usage
//   input beats (s_axis) carry an action in tuser: load one spin, set the
//   running energy (clears the raster counter), or update the next site in
//   raster order. every input beat gives exactly one output beat (m_axis);
//   tlast marks the update of the last site of a sweep.
//   thresholds and coupling are written over the apb port while idle.
// sequencing
//   load, set and unused actions go from accept to the done state; an update
//   passes the read states and the decision state before the done state. a new
//   beat is taken only once the last result has moved to the output register.
//   the five lattice reads go through the two read ports of the lattice ram
//   in the read states (north/south, west/east, center), then the decision
//   state decides and writes the flipped spin back, and the done state moves
//   the result into the output register; tready returns with the result.
// reset
//   energy and raster counter clear, coupling 1, thresholds 0. the lattice
//   ram is not cleared: every site must be loaded before it is updated.
// stalls
//   a finished result waits in the output register while the next beat is
//   taken; a second result waits in its own stage until that register frees.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update #(
    parameter int SIDE = ismu_pkg::SIDE_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // site[7:0], spin_up[8], energy_value[21:9], random_fraction[37:22]
    input  logic [39:0]                 s_axis_tdata,
    // action[1:0]
    input  logic [1:0]                  s_axis_tuser,
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // site_index[7:0], flipped[8], spin_now[9], delta_energy[16:10],
    // total_energy[29:17]
    output logic [31:0]                 m_axis_tdata,
    output logic                        m_axis_tlast,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ismu_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ismu_pkg::*;

    localparam int SITES = SIDE * SIDE;
    localparam int AW    = $clog2(SITES);
    localparam int CW    = $clog2(SIDE);
    localparam logic [12:0] SITES_W = 13'(SITES);
    localparam logic [CW-1:0] LAST  = CW'(SIDE - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RD_NS = 6'b000010,
        ST_RD_EW = 6'b000100,
        ST_RD_C  = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(SIDE) + AW'(c));
    endfunction

    // control state
    state_t             state_reg,  state_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [12:0] energy_reg, energy_next;
    logic [CW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;

    // payload
    logic [3:0]         nb_reg;          // north, south, west, east
    logic [7:0]         res_site_reg;
    logic               res_flip_reg;
    logic               res_spin_reg;
    logic signed [6:0]  res_delta_reg;
    logic signed [12:0] res_energy_reg;
    logic               res_end_reg;
    logic [31:0]        out_data_reg;
    logic               out_last_reg;

    // input fields
    logic [1:0]         in_action;
    logic [7:0]         in_site;
    logic               in_spin;
    logic signed [12:0] in_energy;
    logic [15:0]        in_rnd;
    logic [15:0]        rnd_reg;

    logic               in_accept;
    logic               load_ok;
    logic               out_load;

    // neighbor coordinates with periodic wrap
    logic [CW-1:0]      row_up, row_dn, col_lf, col_rt;
    logic [AW-1:0]      center_addr;
    logic               last_site;

    // lattice ram ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_wdata;
    logic [AW-1:0]      ram_raddr_a, ram_raddr_b;
    logic               ram_rdata_a, ram_rdata_b;

    cfg_t               cfg;
    eval_t              ev;

    assign in_action = s_axis_tuser;
    assign in_site   = s_axis_tdata[7:0];
    assign in_spin   = s_axis_tdata[8];
    assign in_energy = signed'(s_axis_tdata[21:9]);
    assign in_rnd    = s_axis_tdata[37:22];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign load_ok       = ({5'd0, in_site} < SITES_W);

    assign row_up      = (row_reg == '0)  ? LAST : row_reg - 1'b1;
    assign row_dn      = (row_reg == LAST) ? '0  : row_reg + 1'b1;
    assign col_lf      = (col_reg == '0)  ? LAST : col_reg - 1'b1;
    assign col_rt      = (col_reg == LAST) ? '0  : col_reg + 1'b1;
    assign center_addr = site_addr(row_reg, col_reg);
    assign last_site   = (row_reg == LAST) && (col_reg == LAST);

    ismu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ismu_ram #(
        .WIDTH (1),
        .DEPTH (SITES)
    ) u_lattice (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    // center spin arrives from port a during the decision cycle
    ismu_eval u_eval (
        .cfg             (cfg),
        .center          (ram_rdata_a),
        .neighbors       (nb_reg),
        .random_fraction (rnd_reg),
        .energy          (energy_reg),
        .result          (ev)
    );

    // read address schedule: north/south, then west/east, then center
    always_comb
    begin
        case (state_reg)
            ST_RD_NS:
            begin
                ram_raddr_a = site_addr(row_up, col_reg);
                ram_raddr_b = site_addr(row_dn, col_reg);
            end
            ST_RD_EW:
            begin
                ram_raddr_a = site_addr(row_reg, col_lf);
                ram_raddr_b = site_addr(row_reg, col_rt);
            end
            default:
            begin
                ram_raddr_a = center_addr;
                ram_raddr_b = center_addr;
            end
        endcase
    end

    // spin loads write at accept, flips write back in the decision cycle;
    // the next item reads only after the done and idle states have passed
    always_comb
    begin
        if (state_reg == ST_EVAL)
        begin
            ram_we    = ev.flip;
            ram_waddr = center_addr;
            ram_wdata = ~ram_rdata_a;
        end
        else
        begin
            ram_we    = in_accept && (in_action == ACT_LOAD) && load_ok;
            ram_waddr = AW'(in_site);
            ram_wdata = in_spin;
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    // next state
    always_comb
    begin
        state_next     = state_reg;
        energy_next    = energy_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_action == ACT_UPDATE)
                    begin
                        state_next = ST_RD_NS;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                    if (in_action == ACT_SET)
                    begin
                        energy_next = in_energy;
                        row_next    = '0;
                        col_next    = '0;
                    end
                end
            end
            ST_RD_NS: state_next = ST_RD_EW;
            ST_RD_EW: state_next = ST_RD_C;
            ST_RD_C:  state_next = ST_EVAL;
            ST_EVAL:
            begin
                state_next  = ST_DONE;
                energy_next = ev.energy;
                // raster advance with wrap at the end of a sweep
                if (col_reg == LAST)
                begin
                    col_next = '0;
                    row_next = (row_reg == LAST) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            energy_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            energy_reg    <= energy_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rnd_reg <= in_rnd;
            case (in_action)
                ACT_LOAD:
                begin
                    res_site_reg   <= in_site;
                    res_spin_reg   <= load_ok ? in_spin : 1'b0;
                    res_energy_reg <= energy_reg;
                end
                ACT_SET:
                begin
                    res_site_reg   <= 8'd0;
                    res_spin_reg   <= 1'b0;
                    res_energy_reg <= in_energy;
                end
                default:
                begin
                    res_site_reg   <= 8'd0;
                    res_spin_reg   <= 1'b0;
                    res_energy_reg <= energy_reg;
                end
            endcase
            res_flip_reg  <= 1'b0;
            res_delta_reg <= '0;
            res_end_reg   <= 1'b0;
        end

        if (state_reg == ST_RD_EW)
        begin
            nb_reg[0] <= ram_rdata_a;
            nb_reg[1] <= ram_rdata_b;
        end
        if (state_reg == ST_RD_C)
        begin
            nb_reg[2] <= ram_rdata_a;
            nb_reg[3] <= ram_rdata_b;
        end

        if (state_reg == ST_EVAL)
        begin
            res_site_reg   <= 8'(center_addr);
            res_flip_reg   <= ev.flip;
            res_spin_reg   <= ram_rdata_a ^ ev.flip;
            res_delta_reg  <= ev.delta;
            res_energy_reg <= ev.energy;
            res_end_reg    <= last_site;
        end

        if (out_load)
        begin
            out_data_reg <= {2'b00, res_energy_reg, res_delta_reg, res_spin_reg,
                             res_flip_reg, res_site_reg};
            out_last_reg <= res_end_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // raster position stays inside the lattice
    assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= LAST) && (col_reg <= LAST))
        else $error("raster position out of range");

    // the energy only moves on a set beat or a decision cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && (in_action == ACT_SET)) && (state_reg != ST_EVAL)
        |=> $stable(energy_reg))
        else $error("energy changed outside set or update");

    // a sweep end always reports the last site of the lattice
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == 8'(SITES - 1))
        else $error("sweep end on a site other than the last");

    // the decision cycle always hands its result to the output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |=> (state_reg == ST_DONE))
        else $error("update result lost after decision");

endmodule

[src/ismu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ismu_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module ismu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[src/ismu_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ismu_cfg
// apb register file: coupling and the two acceptance thresholds
// ----------------------------------------------------------------------------
module ismu_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ismu_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output ismu_pkg::cfg_t               cfg
);
    import ismu_pkg::*;

    logic [3:0]  coupling_reg;
    logic [15:0] accept_small_reg;
    logic [15:0] accept_large_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;
    logic [3:0]  coupling_in;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    // -8 is outside the coupling range, clamp to -7
    assign coupling_in = (pwdata[3:0] == COUPLING_MIN_RAW) ? COUPLING_FLOOR : pwdata[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupling_reg     <= COUPLING_RESET;
            accept_small_reg <= 16'd0;
            accept_large_reg <= 16'd0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_COUPLING:     coupling_reg     <= coupling_in;
                REG_ACCEPT_SMALL: accept_small_reg <= pwdata[15:0];
                REG_ACCEPT_LARGE: accept_large_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_COUPLING:     prdata = {{28{coupling_reg[3]}}, coupling_reg};
            REG_ACCEPT_SMALL: prdata = {16'd0, accept_small_reg};
            REG_ACCEPT_LARGE: prdata = {16'd0, accept_large_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.coupling     = signed'(coupling_reg);
    assign cfg.accept_small = accept_small_reg;
    assign cfg.accept_large = accept_large_reg;

endmodule

[src/ismu_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ismu_eval
// metropolis decision: energy change, acceptance and saturated energy
// ----------------------------------------------------------------------------
module ismu_eval (
    input  ismu_pkg::cfg_t     cfg,
    input  logic               center,
    input  logic [3:0]         neighbors,
    input  logic [15:0]        random_fraction,
    input  logic signed [12:0] energy,
    output ismu_pkg::eval_t    result
);
    import ismu_pkg::*;

    logic [2:0]         n_up;
    logic signed [4:0]  sum;
    logic signed [4:0]  ssum;
    logic signed [6:0]  ssum_ext;
    logic signed [6:0]  j_ext;
    logic signed [6:0]  prod;
    logic signed [6:0]  delta;
    logic [2:0]         aj;
    logic signed [6:0]  four_aj;
    logic               accept;
    logic signed [13:0] e_sum;
    logic signed [12:0] e_sat;

    always_comb
    begin
        n_up     = 3'(neighbors[0]) + 3'(neighbors[1]) + 3'(neighbors[2])
                 + 3'(neighbors[3]);
        // neighbor sum in -4..4, then signed by the center spin
        sum      = signed'({1'b0, n_up, 1'b0}) - 5'sd4;
        ssum     = center ? sum : -sum;
        ssum_ext = {{2{ssum[4]}}, ssum};
        j_ext    = {{3{cfg.coupling[3]}}, cfg.coupling};
        prod     = 7'(j_ext * ssum_ext);
        delta    = prod <<< 1;

        aj       = cfg.coupling[3] ? 3'(-cfg.coupling) : cfg.coupling[2:0];
        four_aj  = signed'({2'b00, aj, 2'b00});

        if (delta <= 7'sd0)
        begin
            accept = 1'b1;
        end
        else if (delta == four_aj)
        begin
            accept = random_fraction < cfg.accept_small;
        end
        else
        begin
            accept = random_fraction < cfg.accept_large;
        end

        e_sum = {energy[12], energy} + {{7{delta[6]}}, delta};
        if (e_sum[13] != e_sum[12])
        begin
            e_sat = e_sum[13] ? 13'sh1000 : 13'sh0fff;
        end
        else
        begin
            e_sat = e_sum[12:0];
        end

        result.delta  = delta;
        result.flip   = accept;
        result.energy = accept ? e_sat : energy;
    end

endmodule

[test/ising_metropolis_site_update_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_site_update_tb
// self-checking bench for the metropolis site update block: every input beat
// is predicted against a private copy of the lattice, energy, raster counter
// and registers, and each output beat is checked field by field in order
// ----------------------------------------------------------------------------
module ising_metropolis_site_update_tb;

    import ismu_pkg::*;

    localparam int SIDE        = SIDE_DEFAULT;
    localparam int SITES       = SIDE * SIDE;
    localparam int E_MAX       = 4095;
    localparam int E_MIN       = -4096;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;

    // one predicted output beat
    typedef struct packed {
        logic [7:0]         site_index;
        logic               flipped;
        logic               spin_now;
        logic signed [6:0]  delta;
        logic signed [12:0] total;
        logic               sweep_end;
    } site_result_t;

    // lattice predictor and in-order result checker
    class metropolis_scoreboard;
        bit           spins [SITES];
        int           energy    = 0;
        int           raster    = 0;
        int           coupling  = 1;
        logic [15:0]  thr_small = 16'd0;
        logic [15:0]  thr_large = 16'd0;
        site_result_t expected_q [$];
        int           errors    = 0;

        function int spin_of(int idx);
            return spins[idx] ? 1 : -1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            logic signed [3:0] raw;
            raw = value[3:0];
            case (idx)
                REG_COUPLING:
                begin
                    // the most negative code saturates to the stated range
                    coupling = raw;
                    if (coupling < -7)
                        coupling = -7;
                end
                REG_ACCEPT_SMALL: thr_small = value[15:0];
                REG_ACCEPT_LARGE: thr_large = value[15:0];
                default: ;
            endcase
        endfunction

        function void note_beat(logic [1:0] act, logic [39:0] data);
            site_result_t      res;
            logic signed [12:0] ev;
            int                r;
            int                k;
            int                sum;
            int                delta;
            int                mag;
            int                e;
            bit                take;
            res = '0;
            case (act)
                ACT_LOAD:
                begin
                    res.site_index = data[7:0];
                    if (data[7:0] < SITES)
                    begin
                        spins[data[7:0]] = data[8];
                        res.spin_now     = data[8];
                    end
                end
                ACT_SET:
                begin
                    ev     = data[21:9];
                    energy = ev;
                    raster = 0;
                end
                ACT_UPDATE:
                begin
                    r   = raster / SIDE;
                    k   = raster % SIDE;
                    // four wrapped neighbours
                    sum = spin_of(((r + SIDE - 1) % SIDE) * SIDE + k)
                        + spin_of(((r + 1) % SIDE) * SIDE + k)
                        + spin_of(r * SIDE + (k + SIDE - 1) % SIDE)
                        + spin_of(r * SIDE + (k + 1) % SIDE);
                    delta = 2 * coupling * spin_of(raster) * sum;
                    mag   = (coupling < 0) ? -coupling : coupling;
                    if (delta <= 0)
                        take = 1'b1;
                    else if (delta == 4 * mag)
                        take = data[37:22] < thr_small;
                    else
                        take = data[37:22] < thr_large;
                    if (take)
                    begin
                        e = energy + delta;
                        if (e > E_MAX)
                            e = E_MAX;
                        if (e < E_MIN)
                            e = E_MIN;
                        energy         = e;
                        spins[raster]  = !spins[raster];
                        res.flipped    = 1'b1;
                    end
                    res.site_index = 8'(raster);
                    res.spin_now   = spins[raster];
                    res.delta      = 7'(delta);
                    if (raster == SITES - 1)
                    begin
                        res.sweep_end = 1'b1;
                        raster        = 0;
                    end
                    else
                        raster++;
                end
                default: ;
            endcase
            res.total = 13'(energy);
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t mismatch on %s: expected %0d actual %0d",
                             $realtime, name, want, got);
            end
        endfunction

        function void check_beat(logic [31:0] data, logic last);
            site_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t result beat %h with nothing expected", $realtime, data);
                return;
            end
            want = expected_q.pop_front();
            check_field("site_index", want.site_index, data[7:0]);
            check_field("flipped", want.flipped, data[8]);
            check_field("spin_now", want.spin_now, data[9]);
            check_field("delta_energy", want.delta, $signed(data[16:10]));
            check_field("total_energy", want.total, $signed(data[29:17]));
            check_field("sweep_end", want.sweep_end, last);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // site[7:0], spin_up[8], energy_value[21:9], random_fraction[37:22]
    logic [39:0]         s_axis_tdata;
    // action[1:0]
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // site_index[7:0], flipped[8], spin_now[9], delta_energy[16:10],
    // total_energy[29:17]
    logic [31:0]         m_axis_tdata;
    logic                m_axis_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    metropolis_scoreboard sb;

    // both sides skip random idling while this is set
    bit steady    = 1'b0;
    // request for one long receiver hold-off
    bit hold_req  = 1'b0;
    int hold_left = 0;

    ising_metropolis_site_update #(
        .SIDE(SIDE)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 clk = ~clk;

    // receiver: random back-pressure, a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (steady)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 32);
    end

    // every accepted result beat goes to the checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast);
    end

    // hard stop if the run hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("ising_metropolis_site_update_tb: FAIL");
        $finish;
    end

    // input beat layout, spare top bits stay zero
    function automatic logic [39:0] pack_beat(logic [7:0] site, logic up,
                                              logic [12:0] ev, logic [15:0] rnd);
        return {2'b00, rnd, ev, up, site};
    endfunction

    // starting energy, mostly inside the physical range, sometimes any code
    function automatic logic [12:0] rand_energy();
        logic [12:0] ev;
        if ($urandom_range(9) == 0)
            ev = 13'($urandom);
        else
            ev = 13'($urandom_range(7168) - 3584);
        return ev;
    endfunction

    // random fraction, often right at one of the thresholds
    function automatic logic [15:0] rand_fraction();
        logic [15:0] v;
        case ($urandom_range(3))
            0:       v = 16'(sb.thr_small + $urandom_range(2) - 1);
            1:       v = 16'(sb.thr_large + $urandom_range(2) - 1);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // offer one beat, called and returning just after a falling edge
    task automatic send_beat(logic [1:0] act, logic [39:0] data);
        while (!steady && $urandom_range(99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_beat(act, data);
        @(negedge clk);
    endtask

    task automatic send_update();
        send_beat(ACT_UPDATE, pack_beat(8'($urandom), 1'($urandom), 13'($urandom),
                                        rand_fraction()));
    endtask

    // drop valid and drain every outstanding result
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // apb write: setup then access, register taken at the access edge
    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // new random settings, thresholds often at their extremes
    task automatic random_config();
        logic [15:0] thr;
        int          n;
        reg_write(REG_COUPLING, $urandom_range(15));
        for (n = 0; n < 2; n++)
        begin
            case ($urandom_range(3))
                0:       thr = 16'h0000;
                1:       thr = 16'hFFFF;
                default: thr = 16'($urandom);
            endcase
            reg_write(n ? REG_ACCEPT_LARGE : REG_ACCEPT_SMALL, {16'd0, thr});
        end
    endtask

    // sweeps: set energy then a run of updates, with stray loads and
    // unused actions mixed in; some runs carry on without a set
    task automatic run_phase(int n_items, int run_min, int run_max, int hold_at);
        int issued;
        int len;
        int pick;
        issued = 0;
        while (issued < n_items)
        begin
            if ($urandom_range(9) != 0)
            begin
                send_beat(ACT_SET, pack_beat(8'($urandom), 1'($urandom), rand_energy(),
                                             16'($urandom)));
                issued++;
            end
            len = $urandom_range(run_max, run_min);
            repeat (len)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                begin
                    send_beat(ACT_LOAD, pack_beat(8'($urandom), 1'($urandom),
                                                  13'($urandom), 16'($urandom)));
                    issued++;
                end
                else if (pick < 8)
                begin
                    send_beat(ACT_NONE, pack_beat(8'($urandom), 1'($urandom),
                                                  13'($urandom), 16'($urandom)));
                    issued++;
                end
                send_update();
                issued++;
                // one hold-off per phase, the sender keeps offering beats
                if (hold_at >= 0 && issued >= hold_at)
                begin
                    hold_req = 1'b1;
                    hold_at  = -1;
                end
            end
        end
    endtask

    initial
    begin
        int i;
        int p;
        sb            = new;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_LOAD;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // hot lattice, every proposed flip accepted for small random numbers
        reg_write(REG_COUPLING, 32'd7);
        reg_write(REG_ACCEPT_SMALL, 32'hFFFF);
        reg_write(REG_ACCEPT_LARGE, 32'hFFFF);

        // every site loaded before any update can read it
        for (i = 0; i < SITES; i++)
            send_beat(ACT_LOAD, pack_beat(8'(i), 1'($urandom), 13'($urandom),
                                          16'($urandom)));

        // unused action with every field bit set
        send_beat(ACT_NONE, pack_beat(8'hFF, 1'b1, 13'h1FFF, 16'hFFFF));
        // energy pinned at the top, accepted rises must saturate
        send_beat(ACT_SET, pack_beat(8'h00, 1'b0, 13'h0FFF, 16'h0000));
        repeat (6)
            send_beat(ACT_UPDATE, pack_beat(8'hFF, 1'b1, 13'h1FFF, 16'h0000));
        // full-scale random number never beats a full-scale threshold
        send_beat(ACT_UPDATE, pack_beat(8'h00, 1'b0, 13'h0000, 16'hFFFF));
        // energy pinned at the bottom, falls must saturate
        send_beat(ACT_SET, pack_beat(8'hFF, 1'b1, 13'h1000, 16'hFFFF));
        repeat (6)
            send_beat(ACT_UPDATE, pack_beat(8'h00, 1'b0, 13'h0000, 16'hFFFF));

        // most negative coupling code, zero thresholds never accept a rise
        wait_idle();
        reg_write(REG_COUPLING, 32'h8);
        reg_write(REG_ACCEPT_SMALL, 32'h0);
        reg_write(REG_ACCEPT_LARGE, 32'h0);
        repeat (4)
            send_beat(ACT_UPDATE, pack_beat(8'h00, 1'b0, 13'h0000, 16'h0000));

        // zero coupling: every update flips at no cost
        wait_idle();
        reg_write(REG_COUPLING, 32'h0);
        repeat (2)
            send_update();
        send_beat(ACT_SET, pack_beat(8'($urandom), 1'($urandom), -13'sd3584,
                                     16'($urandom)));
        send_beat(ACT_SET, pack_beat(8'($urandom), 1'($urandom), 13'sd3584,
                                     16'($urandom)));

        // random phases; phase 2 is one long sweep past the wrap with no
        // idling, phase 3 carries the long receiver hold-off
        for (p = 0; p < 6; p++)
        begin
            wait_idle();
            random_config();
            steady = (p == 2);
            if (p == 2)
                run_phase(290, 280, 300, -1);
            else
                run_phase(20, 1, 12, (p == 3) ? 8 : -1);
        end
        steady = 1'b0;

        // drain, then give the pipeline time to show any stray beat
        wait_idle();
        repeat (12) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ising_metropolis_site_update_tb: PASS");
        else
            $display("ising_metropolis_site_update_tb: FAIL");
        $finish;
    end

endmodule
